/* design/bbs_pkg.sv */
package bbs_pkg;

  localparam int WINDOW     = 20;
  localparam int PRICE_BITS = 24;
  localparam int BW_W       = 5;
  localparam int BW_RESET   = 8;

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SLOT_W = LOG_W;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = PRICE_BITS + LOG_W;
  localparam int SQ_W   = 2 * PRICE_BITS + LOG_W;
  localparam int PSQ_W  = 2 * PRICE_BITS;
  localparam int VAR_W  = SQ_W + LOG_W;
  localparam int KK_W   = 2 * BW_W;
  localparam int LHS_W  = 2 * SUM_W + 4;
  localparam int CMP_W  = VAR_W + KK_W;
  localparam int VLO_W  = VAR_W / 2;
  localparam int VHI_W  = VAR_W - VLO_W;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_UPD
  } front_state_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [SUM_W-1:0]      sum;
    logic [SQ_W-1:0]       sq_sum;
    logic                  full;
  } front_item_t;

  typedef struct packed {
    action_t action;
    logic    window_full;
  } result_t;

endpackage

/* design/bbs_front.sv */
module bbs_front
  import bbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [PRICE_BITS-1:0] price,
  output logic                  full,
  input  logic                  mid_full,
  output logic                  mid_push,
  output front_item_t           item
);

  front_state_t state, state_next;

  logic [PRICE_BITS-1:0] ring [WINDOW];
  logic [SLOT_W-1:0]     slot, slot_next;
  logic [FILL_W-1:0]     fill, fill_next;
  logic [SUM_W-1:0]      sum, sum_next;
  logic [SQ_W-1:0]       sq_sum, sq_sum_next;
  logic [PRICE_BITS-1:0] price_q;
  logic [PRICE_BITS-1:0] old_q;
  logic [PRICE_BITS-1:0] old_m;
  logic                  was_full;
  logic [PSQ_W-1:0]      pp;
  logic [PSQ_W-1:0]      oo;
  logic                  accept;
  logic                  ring_we;

  assign accept = push && !full;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (push) state_next = F_MUL;
      F_MUL:  state_next = F_UPD;
      F_UPD:  if (!mid_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full     = (state != F_IDLE);
    ring_we  = (state == F_MUL);
    mid_push = (state == F_UPD) && !mid_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read the slot about to be replaced, write it once the old value is captured
  always_ff @(posedge clk) begin
    if (accept) begin
      old_q <= ring[slot];
    end
    if (ring_we) begin
      ring[slot] <= price_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      price_q  <= price;
      was_full <= (fill == FILL_W'(WINDOW));
    end
    if (state == F_MUL) begin
      pp    <= PSQ_W'(price_q) * PSQ_W'(price_q);
      oo    <= was_full ? PSQ_W'(old_q) * PSQ_W'(old_q) : '0;
      old_m <= was_full ? old_q : '0;
    end
  end

  always_comb begin
    sum_next    = sum - SUM_W'(old_m) + SUM_W'(price_q);
    sq_sum_next = sq_sum - SQ_W'(oo) + SQ_W'(pp);
    fill_next   = (fill == FILL_W'(WINDOW)) ? fill : fill + 1'b1;
    slot_next   = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
    item.price  = price_q;
    item.sum    = sum_next;
    item.sq_sum = sq_sum_next;
    item.full   = (fill_next == FILL_W'(WINDOW));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      fill   <= '0;
      sum    <= '0;
      sq_sum <= '0;
    end else if (mid_push) begin
      slot   <= slot_next;
      fill   <= fill_next;
      sum    <= sum_next;
      sq_sum <= sq_sum_next;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == F_MUL)
    else $error("front did not start on an accepted request");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (mid_push && item.full) |=> fill == FILL_W'(WINDOW))
    else $error("window flag disagrees with fill count");
`endif

endmodule

/* design/bbs_item_queue.sv */
module bbs_item_queue
  import bbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t item_in,
  output logic        full,
  input  logic        pop,
  output front_item_t item_out,
  output logic        empty
);

  front_item_t entry [2];
  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        do_push;
  logic        do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 2'd1)
    else $error("queue count lost track of a pop");
`endif

endmodule

/* design/bbs_back.sv */
module bbs_back
  import bbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [BW_W-1:0]  band_width_quarters,
  input  logic             item_empty,
  input  front_item_t      item,
  output logic             item_pop,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       action,
  output logic             window_full
);

  logic [BW_W-1:0] bw;

  logic v1, v2, v3, v4;
  logic en;

  // stage 1: fetched item
  logic [PRICE_BITS-1:0] p1;
  logic [SUM_W-1:0]      s1;
  logic [SQ_W-1:0]       q1;
  logic                  f1;
  logic [SUM_W-1:0]      wp1;
  logic                  low1;
  logic [SUM_W-1:0]      mag1;

  // stage 2: sum squared, scaled sum of squares, deviation magnitude
  logic [VAR_W-1:0]      ss2;
  logic [VAR_W-1:0]      q20_2;
  logic [SUM_W-1:0]      mag2;
  logic [KK_W-1:0]       kk2;
  logic                  low2, f2;

  // stage 3: variance term and squared deviation
  logic [VAR_W-1:0]      var3;
  logic [LHS_W-1:0]      lhs3;
  logic [KK_W-1:0]       kk3;
  logic                  low3, f3;

  // stage 4: partial products of k^2 * variance
  logic [VLO_W+KK_W-1:0] plo4;
  logic [VHI_W+KK_W-1:0] phi4;
  logic [LHS_W-1:0]      lhs4;
  logic                  low4, f4;

  logic [CMP_W-1:0]      rhs;
  logic                  ge;
  result_t               res;

  result_t               oq [2];
  logic [1:0]            oq_count;
  logic                  oq_wr, oq_rd;
  logic                  oq_full;
  logic                  oq_push;
  logic                  oq_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      bw <= BW_W'(BW_RESET);
    end else if (cfg_write) begin
      bw <= band_width_quarters;
    end
  end

  // stall the whole pipe only when the last stage cannot drain
  assign oq_full  = (oq_count == 2'd2);
  assign en       = !(v4 && oq_full);
  assign item_pop = en && !item_empty;
  assign oq_push  = v4 && !oq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= !item_empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    wp1  = SUM_W'(WINDOW) * SUM_W'(p1);
    low1 = (s1 >= wp1);
    mag1 = low1 ? s1 - wp1 : wp1 - s1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= item.price;
      s1 <= item.sum;
      q1 <= item.sq_sum;
      f1 <= item.full;

      ss2   <= VAR_W'(s1) * VAR_W'(s1);
      q20_2 <= VAR_W'(q1) * VAR_W'(WINDOW);
      mag2  <= mag1;
      kk2   <= KK_W'(bw) * KK_W'(bw);
      low2  <= low1;
      f2    <= f1;

      var3 <= q20_2 - ss2;
      lhs3 <= {(2*SUM_W)'(mag2) * (2*SUM_W)'(mag2), 4'b0000};
      kk3  <= kk2;
      low3 <= low2;
      f3   <= f2;

      plo4 <= (VLO_W+KK_W)'(var3[VLO_W-1:0]) * (VLO_W+KK_W)'(kk3);
      phi4 <= (VHI_W+KK_W)'(var3[VAR_W-1:VLO_W]) * (VHI_W+KK_W)'(kk3);
      lhs4 <= lhs3;
      low4 <= low3;
      f4   <= f3;
    end
  end

  always_comb begin
    rhs             = (CMP_W'(phi4) << VLO_W) + CMP_W'(plo4);
    ge              = (CMP_W'(lhs4) >= rhs);
    res.action      = (f4 && ge) ? (low4 ? ACT_BUY : ACT_SELL) : ACT_HOLD;
    res.window_full = f4;
  end

  // result queue
  assign empty       = (oq_count == 2'd0);
  assign oq_pop      = pop && !empty;
  assign action      = oq[oq_rd].action;
  assign window_full = oq[oq_rd].window_full;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_count <= '0;
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
    end else begin
      if (oq_push) oq_wr <= ~oq_wr;
      if (oq_pop) oq_rd <= ~oq_rd;
      unique case ({oq_push, oq_pop})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

`ifndef SYNTH
  a_var_nonneg: assert property (@(posedge clk) disable iff (rst)
    (v2 && f2) |-> q20_2 >= ss2)
    else $error("window sums inconsistent: negative variance");

  a_hold_when_filling: assert property (@(posedge clk) disable iff (rst)
    (oq_push && !res.window_full) |-> res.action == ACT_HOLD)
    else $error("trade signal before the window filled");
`endif

endmodule

/* design/bollinger_band_signal.sv */
// The front sequencer takes one price at a time and holds full until it is through
// with the last one (ring read, squaring, running sum update); the back pipeline takes
// one per cycle, but stalls while its last stage is valid and the result queue is full.
// Reset clears the fill count, ring pointer, running sums and both queues,
// and sets band_width_quarters to 8; the price ring itself is not cleared.
module bollinger_band_signal
  import bbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [PRICE_BITS-1:0] price,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output logic [1:0]            action,
  output logic                  window_full,
  input  logic                  cfg_write,
  input  logic [BW_W-1:0]       band_width_quarters
);

  front_item_t front_item;
  front_item_t back_item;
  logic        mid_push;
  logic        mid_full;
  logic        mid_pop;
  logic        mid_empty;

  bbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .price    (price),
    .full     (full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .item     (front_item)
  );

  bbs_item_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .item_in  (front_item),
    .full     (mid_full),
    .pop      (mid_pop),
    .item_out (back_item),
    .empty    (mid_empty)
  );

  bbs_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .band_width_quarters (band_width_quarters),
    .item_empty          (mid_empty),
    .item                (back_item),
    .item_pop            (mid_pop),
    .pop                 (pop),
    .empty               (empty),
    .action              (action),
    .window_full         (window_full)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bbs_pkg::*;

  localparam int DIR_ROWS        = 25;
  localparam int NUM_PHASES      = 16;
  localparam int PHASE_ITEMS     = 25;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 12;
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

  typedef struct {
    bit                    cfg_en;
    logic [BW_W-1:0]       cfg_val;
    logic [PRICE_BITS-1:0] tick;
    bit                    typed;
    result_t               res;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic [PRICE_BITS-1:0] price;
  logic                  full;
  logic                  pop;
  logic                  empty;
  logic [1:0]            action;
  logic                  window_full;
  logic                  cfg_write;
  logic [BW_W-1:0]       band_width_quarters;

  // band predictor state
  logic [PRICE_BITS-1:0] ring_q [WINDOW];
  int unsigned           slot_q;
  int unsigned           fill_q;
  logic [127:0]          band_sum;
  logic [127:0]          band_sq_sum;
  logic [BW_W-1:0]       bw_q;

  result_t     outcome_q [$];
  int unsigned tx_max_gap;
  int unsigned rx_max_stall;
  bit          hold_off_req;
  int unsigned fail_count;
  int unsigned prices_sent;
  int unsigned results_checked;
  int unsigned buy_count;
  int unsigned sell_count;
  int unsigned hold_count;
  int unsigned band_writes;

  bollinger_band_signal u_top (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .price               (price),
    .full                (full),
    .pop                 (pop),
    .empty               (empty),
    .action              (action),
    .window_full         (window_full),
    .cfg_write           (cfg_write),
    .band_width_quarters (band_width_quarters)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Push one price through the ring and running sums, then apply the band test.
  function automatic result_t advance_band(logic [PRICE_BITS-1:0] p);
    logic [PRICE_BITS-1:0] oldest;
    logic [127:0]          wp;
    logic [127:0]          dev;
    logic [127:0]          spread;
    logic [127:0]          lhs;
    logic [127:0]          rhs;
    logic                  low_side;
    result_t               r;
    if (fill_q == WINDOW) begin
      oldest      = ring_q[slot_q];
      band_sum    = band_sum - 128'(oldest);
      band_sq_sum = band_sq_sum - 128'(oldest) * 128'(oldest);
    end
    ring_q[slot_q] = p;
    band_sum       = band_sum + 128'(p);
    band_sq_sum    = band_sq_sum + 128'(p) * 128'(p);
    slot_q         = (slot_q + 1 == WINDOW) ? 0 : slot_q + 1;
    if (fill_q < WINDOW) fill_q++;

    r.action      = ACT_HOLD;
    r.window_full = (fill_q == WINDOW);
    if (r.window_full) begin
      wp       = 128'(WINDOW) * 128'(p);
      low_side = (band_sum >= wp);
      dev      = low_side ? band_sum - wp : wp - band_sum;
      spread   = 128'(WINDOW) * band_sq_sum - band_sum * band_sum;
      lhs      = 128'(16) * dev * dev;
      rhs      = spread * (128'(bw_q) * 128'(bw_q));
      // the low-side test includes equality, so a tie at zero deviation goes to buy
      if (lhs >= rhs) r.action = low_side ? ACT_BUY : ACT_SELL;
    end
    return r;
  endfunction

  task automatic offer_price(input logic [PRICE_BITS-1:0] p, input bit typed,
                             input result_t typed_res);
    int unsigned gap;
    result_t     r;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    price <= p;
    do @(posedge clk); while (full);
    r = advance_band(p);
    outcome_q.push_back(typed ? typed_res : r);
    prices_sent++;
  endtask

  // Write the band width only once every result is out.
  task automatic write_band(input logic [BW_W-1:0] val);
    push <= 1'b0;
    while (outcome_q.size() != 0 || hold_off_req) @(posedge clk);
    cfg_write           <= 1'b1;
    band_width_quarters <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    bw_q = val;
    band_writes++;
  endtask

  initial begin : drain
    int unsigned stall;
    result_t     exp_r;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = $urandom_range(0, rx_max_stall);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (outcome_q.size() == 0) begin
        $error("result with no request waiting: action %0d window_full %0d",
               action, window_full);
        fail_count++;
      end else begin
        exp_r = outcome_q.pop_front();
        if (action !== exp_r.action) begin
          $error("action mismatch: expected %0d, got %0d", exp_r.action, action);
          fail_count++;
        end
        if (window_full !== exp_r.window_full) begin
          $error("window_full mismatch: expected %0d, got %0d",
                 exp_r.window_full, window_full);
          fail_count++;
        end
        results_checked++;
        case (action)
          ACT_BUY:  buy_count++;
          ACT_SELL: sell_count++;
          default:  hold_count++;
        endcase
      end
    end
  end

  initial begin : stimulus
    dir_row_t              dir_tbl [DIR_ROWS];
    result_t               no_res;
    logic [PRICE_BITS-1:0] base;
    logic [PRICE_BITS-1:0] p;
    logic [BW_W-1:0]       bw;
    int unsigned           style;

    rst                 <= 1'b1;
    push                <= 1'b0;
    price               <= '0;
    cfg_write           <= 1'b0;
    band_width_quarters <= '0;
    for (int i = 0; i < WINDOW; i++) ring_q[i] = '0;
    slot_q       = 0;
    fill_q       = 0;
    band_sum     = '0;
    band_sq_sum  = '0;
    bw_q         = BW_W'(BW_RESET);
    tx_max_gap   = 8;
    rx_max_stall = 8;
    hold_off_req = 1'b0;
    no_res       = '0;

    // Fill with the top price: hold until full, then zero spread gives buy.
    for (int i = 0; i < DIR_ROWS; i++) begin
      dir_tbl[i].cfg_en  = 1'b0;
      dir_tbl[i].cfg_val = '0;
      dir_tbl[i].tick    = PRICE_MAX;
      dir_tbl[i].typed   = (i < WINDOW);
      dir_tbl[i].res     = '{action: ACT_HOLD, window_full: 1'b0};
    end
    dir_tbl[WINDOW-1].res = '{action: ACT_BUY, window_full: 1'b1};
    dir_tbl[20].tick      = '0;
    dir_tbl[22].cfg_en    = 1'b1;
    dir_tbl[22].cfg_val   = '0;
    dir_tbl[22].tick      = 24'h000001;
    dir_tbl[24].cfg_en    = 1'b1;
    dir_tbl[24].cfg_val   = '1;
    dir_tbl[24].tick      = 24'h800000;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tbl[i].cfg_en) write_band(dir_tbl[i].cfg_val);
      offer_price(dir_tbl[i].tick, dir_tbl[i].typed, dir_tbl[i].res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       bw = '0;
        1:       bw = '1;
        2:       bw = BW_W'(BW_RESET);
        3:       bw = BW_W'(1);
        default: bw = BW_W'($urandom_range(0, 31));
      endcase
      write_band(bw);
      case (ph % 4)
        0:       begin tx_max_gap = 8; rx_max_stall = 8; end
        1:       begin tx_max_gap = 0; rx_max_stall = 8; end
        2:       begin tx_max_gap = 8; rx_max_stall = 0; end
        default: begin tx_max_gap = 0; rx_max_stall = 0; end
      endcase
      // stall the result side long enough to back up into the input
      if (ph == 6) begin
        tx_max_gap   = 0;
        hold_off_req = 1'b1;
      end
      style = ph % 5;
      base  = PRICE_BITS'($urandom_range(0, 24'hFFFFF0));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case (style)
          0: p = PRICE_BITS'($urandom());
          1: p = base + PRICE_BITS'($urandom_range(0, 3));
          // long flat run first, so the window goes to zero spread
          2: p = (i >= 21 && $urandom_range(0, 1)) ?
                 ($urandom_range(0, 1) ? PRICE_MAX : '0) : base;
          3: p = ($urandom_range(0, 2) == 0) ? PRICE_BITS'($urandom()) :
                 ($urandom_range(0, 1) ? PRICE_MAX : '0);
          default: begin
            base = base + PRICE_BITS'($urandom_range(0, 64)) - PRICE_BITS'(32);
            p    = base;
          end
        endcase
        offer_price(p, 1'b0, no_res);
      end
    end

    push <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d prices in, %0d results checked (%0d buy, %0d sell, %0d hold)",
             prices_sent, results_checked, buy_count, sell_count, hold_count);
    $display("Summary: %0d band width writes, including 0 and 31, one long output stall",
             band_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
